>>> design/pixel_format_converter_assert.svh
// Assertion macros shared by the pixel format converter RTL.
`ifndef PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define PFC_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pixel format converter assertion failed");

// Next-cycle implication, checked out of reset.
`define PFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pixel format converter assertion failed");

`else

`define PFC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PFC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> design/pfc_pkg.sv
// Types and format codes shared by the pixel format converter modules.
`default_nettype none

package pfc_pkg;

  // Function codes of an input word.
  localparam logic FUNC_CONVERT   = 1'b0;
  localparam logic FUNC_PAL_WRITE = 1'b1;

  // Pixel format codes.
  localparam logic [3:0] FMT_ARGB8888 = 4'd0;
  localparam logic [3:0] FMT_XRGB8888 = 4'd1;
  localparam logic [3:0] FMT_ABGR8888 = 4'd2;
  localparam logic [3:0] FMT_RGBA8888 = 4'd3;
  localparam logic [3:0] FMT_BGRA8888 = 4'd4;
  localparam logic [3:0] FMT_RGB888   = 4'd5;
  localparam logic [3:0] FMT_RGB565A8 = 4'd6;
  localparam logic [3:0] FMT_RGB565   = 4'd7;
  localparam logic [3:0] FMT_BGR565   = 4'd8;
  localparam logic [3:0] FMT_A8L8     = 4'd9;
  localparam logic [3:0] FMT_ARGB4444 = 4'd10;
  localparam logic [3:0] FMT_L8       = 4'd11;
  localparam logic [3:0] FMT_A4L4     = 4'd12;
  localparam logic [3:0] FMT_ARGB1555 = 4'd13;
  localparam logic [3:0] FMT_RGB8     = 4'd14;

  localparam int unsigned PAL_SIZE_W = 9;

  // Input word.
  typedef struct packed {
    logic        func;
    logic [3:0]  src_format;
    logic [3:0]  dst_format;
    logic [31:0] pixel_in;
    logic [7:0]  palette_index;
    logic [31:0] palette_word;
  } pfc_in_t;

  // Result word.
  typedef struct packed {
    logic [31:0] pixel_out;
    logic [2:0]  bytes_per_pixel;
  } pfc_out_t;

  // Unpacked source channels.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic [7:0] lum;
    logic       indexed;
    logic       idx_alpha;
  } pfc_chan_t;

  // Pipeline register between the palette read and the repack.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       hit;
    logic       idx_alpha;
    logic [3:0] dst;
  } pfc_stage_t;

endpackage

`default_nettype wire

>>> design/pfc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module pfc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/pfc_unpack.sv
// Source pixel unpacking into 8-bit channels and a palette index.
`default_nettype none

module pfc_unpack (
  input  wire logic [3:0]  src_format_i,
  input  wire logic [31:0] pixel_i,
  output pfc_pkg::pfc_chan_t chan_o
);

  import pfc_pkg::*;

  always_comb begin
    chan_o = '0;
    unique case (src_format_i)
      FMT_ARGB8888: begin
        chan_o.b = pixel_i[7:0];
        chan_o.g = pixel_i[15:8];
        chan_o.r = pixel_i[23:16];
        chan_o.a = pixel_i[31:24];
      end
      FMT_XRGB8888, FMT_RGB888: begin
        chan_o.b = pixel_i[7:0];
        chan_o.g = pixel_i[15:8];
        chan_o.r = pixel_i[23:16];
        chan_o.a = 8'hff;
      end
      FMT_ABGR8888: begin
        chan_o.r = pixel_i[7:0];
        chan_o.g = pixel_i[15:8];
        chan_o.b = pixel_i[23:16];
        chan_o.a = pixel_i[31:24];
      end
      FMT_RGBA8888: begin
        chan_o.a = pixel_i[7:0];
        chan_o.b = pixel_i[15:8];
        chan_o.g = pixel_i[23:16];
        chan_o.r = pixel_i[31:24];
      end
      FMT_BGRA8888: begin
        chan_o.a = pixel_i[7:0];
        chan_o.r = pixel_i[15:8];
        chan_o.g = pixel_i[23:16];
        chan_o.b = pixel_i[31:24];
      end
      FMT_RGB565A8: begin
        chan_o.b = {pixel_i[4:0], 3'b000};
        chan_o.g = {pixel_i[10:5], 2'b00};
        chan_o.r = {pixel_i[15:11], 3'b000};
        chan_o.a = pixel_i[23:16];
      end
      FMT_RGB565: begin
        chan_o.b = {pixel_i[4:0], 3'b000};
        chan_o.g = {pixel_i[10:5], 2'b00};
        chan_o.r = {pixel_i[15:11], 3'b000};
        chan_o.a = 8'hff;
      end
      FMT_BGR565: begin
        chan_o.r = {pixel_i[4:0], 3'b000};
        chan_o.g = {pixel_i[10:5], 2'b00};
        chan_o.b = {pixel_i[15:11], 3'b000};
        chan_o.a = 8'hff;
      end
      FMT_A8L8: begin
        chan_o.a       = pixel_i[15:8];
        chan_o.lum     = pixel_i[7:0];
        chan_o.indexed = 1'b1;
      end
      FMT_L8: begin
        chan_o.a         = 8'hff;
        chan_o.lum       = pixel_i[7:0];
        chan_o.indexed   = 1'b1;
        chan_o.idx_alpha = 1'b1;
      end
      FMT_A4L4: begin
        chan_o.a       = {pixel_i[7:4], 4'h0};
        chan_o.lum     = {4'h0, pixel_i[3:0]};
        chan_o.indexed = 1'b1;
      end
      default: begin
        // Formats without an unpacker give all-zero channels.
        chan_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/pfc_pack.sv
// Palette merge and repacking of channels into the destination format.
`default_nettype none

module pfc_pack (
  input  wire pfc_pkg::pfc_stage_t stage_i,
  input  wire logic [31:0]         pal_entry_i,
  output pfc_pkg::pfc_out_t        result_o
);

  import pfc_pkg::*;

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] a;

  // A palette hit replaces the color channels, and alpha too for L8.
  always_comb begin
    r = stage_i.r;
    g = stage_i.g;
    b = stage_i.b;
    a = stage_i.a;
    if (stage_i.hit) begin
      b = pal_entry_i[7:0];
      g = pal_entry_i[15:8];
      r = pal_entry_i[23:16];
      if (stage_i.idx_alpha) begin
        a = pal_entry_i[31:24];
      end
    end
  end

  always_comb begin
    unique case (stage_i.dst)
      FMT_ARGB8888: result_o.pixel_out = {a, r, g, b};
      FMT_XRGB8888: result_o.pixel_out = {8'h00, r, g, b};
      FMT_ABGR8888: result_o.pixel_out = {a, b, g, r};
      FMT_RGBA8888: result_o.pixel_out = {r, g, b, a};
      FMT_BGRA8888: result_o.pixel_out = {b, g, r, a};
      FMT_RGB888:   result_o.pixel_out = {8'h00, r, g, b};
      FMT_RGB565A8: result_o.pixel_out = {8'h00, a, r[7:3], g[7:2], b[7:3]};
      FMT_RGB565:   result_o.pixel_out = {16'h0000, r[7:3], g[7:2], b[7:3]};
      FMT_BGR565:   result_o.pixel_out = {16'h0000, b[7:3], g[7:2], r[7:3]};
      default:      result_o.pixel_out = '0;
    endcase
    unique case (stage_i.dst) inside
      [FMT_ARGB8888:FMT_BGRA8888]: result_o.bytes_per_pixel = 3'd4;
      [FMT_RGB888:FMT_RGB565A8]:   result_o.bytes_per_pixel = 3'd3;
      [FMT_RGB565:FMT_ARGB4444]:   result_o.bytes_per_pixel = 3'd2;
      [FMT_L8:FMT_RGB8]:           result_o.bytes_per_pixel = 3'd1;
      default:                     result_o.bytes_per_pixel = 3'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/pixel_format_converter.sv
// Top level of the pixel format converter with its palette memory.
`default_nettype none
`include "pixel_format_converter_assert.svh"

// Usage
//   Input channel: a word on in_word_i is taken at a clock edge where start_i
//   is high and busy_o is low. busy_o never rises, so a new word may be issued
//   every cycle. A convert word yields one result word; a palette-write word
//   stores its entry into the palette memory and yields nothing.
//   Result channel: res_valid_o marks a result on res_word_o for exactly one
//   cycle. The receiver must take it then; there is no back-pressure.
//   Pipeline: the palette memory read port is registered and reads an accepted
//   convert word's entry together with the stage-one register, and the
//   repacked word is then registered into the result stage, from which the
//   receiver takes it.
//   Throughput is one word per cycle, set by the single palette write/read
//   port pair: a write and a read never fall in the same cycle, and a read
//   issued after a write sees it.
//   Configuration: cfg_wdata_i sets palette_size when cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while the block is idle.
//   Reset clears palette_size and the pipeline valid flags; the palette
//   contents are undefined until written, and no clearing pass runs.
module pixel_format_converter #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire pfc_pkg::pfc_in_t  in_word_i,
  output logic                   res_valid_o,
  output pfc_pkg::pfc_out_t      res_word_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [8:0]        cfg_wdata_i
);

  import pfc_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam logic [PAL_SIZE_W-1:0] DEPTH_W = PAL_SIZE_W'(PALETTE_DEPTH);

  logic                  accept;
  logic                  is_convert;
  logic                  pal_we;
  logic                  pal_re;
  logic [31:0]           pal_rdata;
  logic [PAL_SIZE_W-1:0] pal_size_q;
  logic [PAL_SIZE_W-1:0] eff_size;
  pfc_chan_t             chan;
  pfc_stage_t            s1_d;
  pfc_stage_t            s1_q;
  logic                  s1_valid_q;
  pfc_out_t              res_d;
  pfc_out_t              res_q;
  logic                  res_valid_q;

  // The pipeline never stalls, so input and configuration are always open.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign accept     = start_i && !busy_o;
  assign is_convert = (in_word_i.func == FUNC_CONVERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pal_size_q <= cfg_wdata_i;
    end
  end

  // Entries at or beyond the memory depth are never valid.
  assign eff_size = (pal_size_q > DEPTH_W) ? DEPTH_W : pal_size_q;

  // A palette write outside the memory is dropped.
  assign pal_we = accept && !is_convert &&
                  ({1'b0, in_word_i.palette_index} < DEPTH_W);

  pfc_unpack u_unpack (
    .src_format_i (in_word_i.src_format),
    .pixel_i      (in_word_i.pixel_in),
    .chan_o       (chan)
  );

  assign pal_re = accept && is_convert && chan.indexed;

  // The read address may alias for indexes beyond a small memory; such
  // indexes never hit because they lie at or above the effective size.
  pfc_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (in_word_i.palette_index[AW-1:0]),
    .wdata_i (in_word_i.palette_word),
    .re_i    (pal_re),
    .raddr_i (chan.lum[AW-1:0]),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    s1_d.r         = chan.r;
    s1_d.g         = chan.g;
    s1_d.b         = chan.b;
    s1_d.a         = chan.a;
    s1_d.hit       = chan.indexed && ({1'b0, chan.lum} < eff_size);
    s1_d.idx_alpha = chan.idx_alpha;
    s1_d.dst       = in_word_i.dst_format;
  end

  // Stage one travels alongside the palette read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && is_convert;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_convert) begin
      s1_q <= s1_d;
    end
  end

  pfc_pack u_pack (
    .stage_i     (s1_q),
    .pal_entry_i (pal_rdata),
    .result_o    (res_d)
  );

  // Result register: each result is shown for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_q;

  // A palette write never produces a stage-one word.
  `PFC_ASSERT_NEXT(a_write_no_stage, clk_i, rst_ni, accept && !is_convert, !s1_valid_q)
  // Every stage-one word reaches the result port in the next cycle.
  `PFC_ASSERT_NEXT(a_stage_to_result, clk_i, rst_ni, s1_valid_q, res_valid_o)
  // No result appears without a stage-one word before it.
  `PFC_ASSERT_NEXT(a_no_spurious_result, clk_i, rst_ni, !s1_valid_q, !res_valid_o)
  // A palette hit in stage one was read from the memory in the previous cycle.
  `PFC_ASSERT_NOW(a_hit_has_read, clk_i, rst_ni, s1_valid_q && s1_q.hit, $past(pal_re))
  // An unknown destination size comes with a zero pixel.
  `PFC_ASSERT_NOW(a_unknown_dst_zero, clk_i, rst_ni,
                  res_valid_o && (res_word_o.bytes_per_pixel == 3'd0),
                  res_word_o.pixel_out == 32'd0)

endmodule

`default_nettype wire
